// ===== src/ctpd_pkg.sv =====
// Shared types and constants of the telemetry packet deframer.
`default_nettype none

package ctpd_pkg;

    // Frame code bytes.
    localparam logic [7:0] CODE_CURRENT    = 8'h1c;
    localparam logic [7:0] CODE_VOLTAGE    = 8'hb3;
    localparam logic [7:0] CODE_CTRL_TEMP  = 8'hf9;
    localparam logic [7:0] CODE_MOTOR_TEMP = 8'h48;
    localparam logic [7:0] CODE_RUDDER     = 8'ha7;
    localparam logic [7:0] CODE_FLAGS      = 8'h8f;
    localparam logic [7:0] CODE_EEPROM     = 8'h9a;
    localparam logic [7:0] CODE_VERSION    = 8'h88;

    // Kind codes reported on the result channel.
    localparam logic [3:0] KIND_CURRENT    = 4'd0;
    localparam logic [3:0] KIND_VOLTAGE    = 4'd1;
    localparam logic [3:0] KIND_CTRL_TEMP  = 4'd2;
    localparam logic [3:0] KIND_MOTOR_TEMP = 4'd3;
    localparam logic [3:0] KIND_RUDDER     = 4'd4;
    localparam logic [3:0] KIND_FLAGS      = 4'd5;
    localparam logic [3:0] KIND_EEPROM     = 4'd6;
    localparam logic [3:0] KIND_VERSION    = 4'd7;
    localparam logic [3:0] KIND_UNKNOWN    = 4'd8;

    localparam logic [7:0]  CRC_INIT       = 8'hFF;
    localparam logic [7:0]  CRC_POLY       = 8'h31;
    localparam logic [7:0]  PKT_CNT_MAX    = 8'd255;
    localparam logic [15:0] RUDDER_NONE    = 16'd65535;
    localparam logic [14:0] VERSION_SCALE  = 15'd100;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] raw_value;
        logic        rudder_missing;
        logic        eeprom_pair_done;
        logic [7:0]  eeprom_pair_addr;
        logic [15:0] eeprom_pair_word;
        logic [14:0] version_number;
        logic [7:0]  packets_seen;
        logic [15:0] status_flags;
    } t_result;

    // Decoder state that persists between packets.
    typedef struct packed {
        logic [7:0]  pkt_cnt;
        logic [15:0] flags;
        logic [7:0]  even_addr;
        logic [7:0]  even_value;
    } t_dec_state;

endpackage

`default_nettype wire

// ===== src/ctpd_decode.sv =====
// Combinational decoder for one synchronized, CRC-checked frame.
`default_nettype none

module ctpd_decode
    import ctpd_pkg::*;
(
    input  wire logic [7:0] i_code,
    input  wire logic [7:0] i_lo,
    input  wire logic [7:0] i_hi,
    input  wire t_dec_state i_state,
    output t_dec_state      o_state,
    output t_result         o_result
);

    logic [3:0]  kind;
    logic [15:0] value;
    logic        pair_hit;

    always_comb begin
        case (i_code)
            CODE_CURRENT:    kind = KIND_CURRENT;
            CODE_VOLTAGE:    kind = KIND_VOLTAGE;
            CODE_CTRL_TEMP:  kind = KIND_CTRL_TEMP;
            CODE_MOTOR_TEMP: kind = KIND_MOTOR_TEMP;
            CODE_RUDDER:     kind = KIND_RUDDER;
            CODE_FLAGS:      kind = KIND_FLAGS;
            CODE_EEPROM:     kind = KIND_EEPROM;
            CODE_VERSION:    kind = KIND_VERSION;
            default:         kind = KIND_UNKNOWN;
        endcase
    end

    assign value = {i_hi, i_lo};

    // An odd address completes a pair only when it directly follows the stored even one.
    assign pair_hit = (kind == KIND_EEPROM) && i_lo[0]
                   && ({1'b0, i_lo} == ({1'b0, i_state.even_addr} + 9'd1));

    always_comb begin
        o_state = i_state;
        if (i_state.pkt_cnt != PKT_CNT_MAX) begin
            o_state.pkt_cnt = i_state.pkt_cnt + 8'd1;
        end
        if (kind == KIND_FLAGS) begin
            o_state.flags = value;
        end
        if ((kind == KIND_EEPROM) && !i_lo[0]) begin
            o_state.even_addr  = i_lo;
            o_state.even_value = i_hi;
        end

        o_result.kind             = kind;
        o_result.raw_value        = value;
        o_result.rudder_missing   = (kind == KIND_RUDDER) && (value == RUDDER_NONE);
        o_result.eeprom_pair_done = pair_hit;
        o_result.eeprom_pair_addr = pair_hit ? i_state.even_addr : 8'd0;
        o_result.eeprom_pair_word = pair_hit ? {i_hi, i_state.even_value} : 16'd0;
        o_result.version_number   = (kind == KIND_VERSION)
                                  ? (15'(i_hi) * VERSION_SCALE + 15'(i_lo)) : 15'd0;
        o_result.packets_seen     = o_state.pkt_cnt;
        o_result.status_flags     = o_state.flags;
    end

endmodule

`default_nettype wire

// ===== src/crc8_telemetry_packet_deframer_unit.sv =====
// Top level of the CRC-8 telemetry packet deframer.
//
// The block takes one received serial byte per item on the input channel
// (i_valid, o_ready, i_rx_byte) and gives at most one decoded packet per item
// on the result channel (o_valid, i_ready and the o_* result fields).
// Bytes gather in a three-byte window; the fourth byte is compared with the
// CRC-8 (polynomial 0x31, start value 0xFF, MSB first) of the window. A good
// CRC consumes the frame, a bad one drops the oldest byte and loses sync.
// After two good frames in a row, every further good frame is decoded.
//
// Throughput is one item per cycle while o_ready is high: the CRC check over
// the window, the code decode and all state updates complete in the cycle
// the byte is accepted. While the output register is free, the result of a
// byte is loaded into it at the edge that accepts the byte.
// When the receiver stalls, the waiting result stays in the output register
// and the next result goes into a one-entry skid register; o_ready drops only
// while the skid register is full, so no result is lost.
// Reset clears the window fill, the sync count, the packet counter, the
// flags word, the stored EEPROM pair and both output valid flags.
`default_nettype none

module crc8_telemetry_packet_deframer_unit
    import ctpd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [3:0]       o_kind,
    output logic [15:0]      o_raw_value,
    output logic             o_rudder_missing,
    output logic             o_eeprom_pair_done,
    output logic [7:0]       o_eeprom_pair_addr,
    output logic [15:0]      o_eeprom_pair_word,
    output logic [14:0]      o_version_number,
    output logic [7:0]       o_packets_seen,
    output logic [15:0]      o_status_flags
);

    localparam logic [1:0] SYNC_DONE = 2'd2;
    localparam logic [1:0] WIN_FULL  = 2'd3;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        r = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
        end
        return r;
    endfunction

    // Window bytes hold payload only; the fill count says which are meaningful.
    logic [7:0] r_win0, r_win1, r_win2;
    logic [1:0] r_fill, n_fill;
    logic [1:0] r_sync, n_sync;
    t_dec_state r_dec, dec_next;
    t_result    dec_res;

    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;

    logic       in_acc, out_acc;
    logic [7:0] win_crc;
    logic       crc_good, res_fire;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = r_out_valid && i_ready;
    assign o_ready = !r_skid_valid;

    assign win_crc  = crc8_update(crc8_update(crc8_update(CRC_INIT, r_win0), r_win1), r_win2);
    assign crc_good = (r_fill == WIN_FULL) && (win_crc == i_rx_byte);
    assign res_fire = in_acc && crc_good && (r_sync == SYNC_DONE);

    ctpd_decode u_decode (
        .i_code   (r_win0),
        .i_lo     (r_win1),
        .i_hi     (r_win2),
        .i_state  (r_dec),
        .o_state  (dec_next),
        .o_result (dec_res)
    );

    always_comb begin
        n_fill = r_fill;
        n_sync = r_sync;
        if (in_acc) begin
            if (r_fill != WIN_FULL) begin
                n_fill = r_fill + 2'd1;
            end else if (crc_good) begin
                n_fill = 2'd0;
                if (r_sync != SYNC_DONE) begin
                    n_sync = r_sync + 2'd1;
                end
            end else begin
                n_sync = 2'd0;
            end
        end
    end

    // Window storage: fill in order, or slide by one byte on a CRC miss.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            case (r_fill)
                2'd0: r_win0 <= i_rx_byte;
                2'd1: r_win1 <= i_rx_byte;
                2'd2: r_win2 <= i_rx_byte;
                default: begin
                    if (!crc_good) begin
                        r_win0 <= r_win1;
                        r_win1 <= r_win2;
                        r_win2 <= i_rx_byte;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 2'd0;
            r_sync <= 2'd0;
            r_dec  <= '0;
        end else begin
            r_fill <= n_fill;
            r_sync <= n_sync;
            if (res_fire) begin
                r_dec <= dec_next;
            end
        end
    end

    // Output register with a one-entry skid stage behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_acc) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= res_fire;
            end
        end else if (res_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_acc) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (res_fire) begin
                r_out <= dec_res;
            end
        end else if (res_fire) begin
            r_skid <= dec_res;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_kind             = r_out.kind;
    assign o_raw_value        = r_out.raw_value;
    assign o_rudder_missing   = r_out.rudder_missing;
    assign o_eeprom_pair_done = r_out.eeprom_pair_done;
    assign o_eeprom_pair_addr = r_out.eeprom_pair_addr;
    assign o_eeprom_pair_word = r_out.eeprom_pair_word;
    assign o_version_number   = r_out.version_number;
    assign o_packets_seen     = r_out.packets_seen;
    assign o_status_flags     = r_out.status_flags;

    // The skid entry is only ever filled behind a waiting output entry.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid while output register empty");

    // The sync count saturates at two good frames.
    a_sync_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sync != 2'd3)
        else $error("sync count out of range");

    // A good frame always empties the window.
    a_good_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && crc_good) |=> (r_fill == 2'd0))
        else $error("window not emptied after good frame");

    // A decoded packet bumps the counter unless it is already saturated.
    a_pkt_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_fire && (r_dec.pkt_cnt != PKT_CNT_MAX))
        |=> (r_dec.pkt_cnt == $past(r_dec.pkt_cnt) + 8'd1))
        else $error("packet counter did not advance");

    // A bad CRC on a full window always drops sync.
    a_bad_crc_unsync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (r_fill == WIN_FULL) && !crc_good) |=> (r_sync == 2'd0 && r_fill == WIN_FULL))
        else $error("bad CRC did not drop sync");

endmodule

`default_nettype wire

// ===== tb/crc8_telemetry_packet_deframer_unit_tb.sv =====
// Self-checking testbench for the CRC-8 telemetry packet deframer.
`default_nettype none

module crc8_telemetry_packet_deframer_unit_tb
    import ctpd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 5;
    // Random stimulus keeps going until this many bytes have gone in.
    localparam int RANDOM_BYTES = 1030;
    // Cycles with no handshake on either side before the run is declared hung.
    // The longest gap that pick_gap gives either side is far below this limit, so it is ample.
    localparam int STALL_LIMIT  = 2000;
    // Idle cycles after the final drain, to catch stray packets.
    localparam int DRAIN_CYCLES = 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_rx_byte;
    logic        o_valid;
    logic        i_ready;
    logic [3:0]  o_kind;
    logic [15:0] o_raw_value;
    logic        o_rudder_missing;
    logic        o_eeprom_pair_done;
    logic [7:0]  o_eeprom_pair_addr;
    logic [15:0] o_eeprom_pair_word;
    logic [14:0] o_version_number;
    logic [7:0]  o_packets_seen;
    logic [15:0] o_status_flags;

    crc8_telemetry_packet_deframer_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_rx_byte          (i_rx_byte),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_kind             (o_kind),
        .o_raw_value        (o_raw_value),
        .o_rudder_missing   (o_rudder_missing),
        .o_eeprom_pair_done (o_eeprom_pair_done),
        .o_eeprom_pair_addr (o_eeprom_pair_addr),
        .o_eeprom_pair_word (o_eeprom_pair_word),
        .o_version_number   (o_version_number),
        .o_packets_seen     (o_packets_seen),
        .o_status_flags     (o_status_flags)
    );

    // CRC-8 over the three leading bytes of a frame: polynomial 0x31, start
    // value 0xFF, MSB first, no final XOR. Used both to build frames and to
    // predict whether the block accepts them.
    function automatic logic [7:0] frame_crc(input logic [7:0] code, input logic [7:0] lo,
                                             input logic [7:0] hi);
        logic [7:0] crc;
        logic [7:0] msg [3];
        msg = '{code, lo, hi};
        crc = CRC_INIT;
        for (int k = 0; k < 3; k++) begin
            crc = crc ^ msg[k];
            for (int j = 0; j < 8; j++) begin
                crc = crc[7] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
            end
        end
        return crc;
    endfunction

    // Predicts the decoded packets from the byte stream and checks what the
    // block delivers against them, in order.
    class packet_decode_scoreboard;
        logic [7:0]  window [3];
        logic [1:0]  window_fill;
        logic [1:0]  sync_run;
        logic [7:0]  pkt_cnt;
        logic [15:0] flags;
        logic [7:0]  even_addr;
        logic [7:0]  even_value;
        t_result     pending_packets [$];
        int          errors;
        int          decoded_total;
        int          crc_drops;
        int          pairs_done;

        function new();
            window = '{8'h00, 8'h00, 8'h00};
            window_fill = '0;
            sync_run = '0;
            pkt_cnt = '0;
            flags = '0;
            even_addr = '0;
            even_value = '0;
            errors = 0;
            decoded_total = 0;
            crc_drops = 0;
            pairs_done = 0;
        endfunction

        // Called for every byte the block accepts.
        function void note_byte(input logic [7:0] b);
            logic [7:0]  code;
            logic [7:0]  lo;
            logic [7:0]  hi;
            logic [15:0] val;
            t_result     pkt;
            if (window_fill < 2'd3) begin
                window[window_fill] = b;
                window_fill = window_fill + 2'd1;
                return;
            end
            code = window[0];
            lo = window[1];
            hi = window[2];
            if (frame_crc(code, lo, hi) != b) begin
                // Slide by one byte and lose sync.
                window[0] = lo;
                window[1] = hi;
                window[2] = b;
                sync_run = '0;
                crc_drops++;
                return;
            end
            window_fill = '0;
            if (sync_run < 2'd2) begin
                sync_run = sync_run + 2'd1;
                return;
            end
            if (pkt_cnt != PKT_CNT_MAX) pkt_cnt = pkt_cnt + 8'd1;
            val = {hi, lo};
            pkt = '0;
            pkt.raw_value = val;
            case (code)
                CODE_CURRENT:    pkt.kind = KIND_CURRENT;
                CODE_VOLTAGE:    pkt.kind = KIND_VOLTAGE;
                CODE_CTRL_TEMP:  pkt.kind = KIND_CTRL_TEMP;
                CODE_MOTOR_TEMP: pkt.kind = KIND_MOTOR_TEMP;
                CODE_RUDDER:     pkt.kind = KIND_RUDDER;
                CODE_FLAGS:      pkt.kind = KIND_FLAGS;
                CODE_EEPROM:     pkt.kind = KIND_EEPROM;
                CODE_VERSION:    pkt.kind = KIND_VERSION;
                default:         pkt.kind = KIND_UNKNOWN;
            endcase
            case (pkt.kind)
                KIND_RUDDER: pkt.rudder_missing = (val == RUDDER_NONE);
                KIND_FLAGS:  flags = val;
                KIND_EEPROM: begin
                    if (lo[0]) begin
                        // An odd address completes a pair only right after its partner.
                        if ({1'b0, lo} == {1'b0, even_addr} + 9'd1) begin
                            pkt.eeprom_pair_done = 1'b1;
                            pkt.eeprom_pair_addr = even_addr;
                            pkt.eeprom_pair_word = {hi, even_value};
                            pairs_done++;
                        end
                    end else begin
                        even_addr = lo;
                        even_value = hi;
                    end
                end
                KIND_VERSION: pkt.version_number = 15'(hi) * VERSION_SCALE + 15'(lo);
                default: ;
            endcase
            pkt.packets_seen = pkt_cnt;
            pkt.status_flags = flags;
            pending_packets.push_back(pkt);
            decoded_total++;
        endfunction

        function void compare_field(input string name, input logic [15:0] want,
                                    input logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        // Called for every packet the block hands over.
        function void check_packet(input t_result got);
            t_result want;
            if (pending_packets.size() == 0) begin
                $error("packet delivered with none expected: kind %0d raw 0x%0h",
                       got.kind, got.raw_value);
                errors++;
                return;
            end
            want = pending_packets.pop_front();
            compare_field("kind", 16'(want.kind), 16'(got.kind));
            compare_field("raw_value", want.raw_value, got.raw_value);
            compare_field("rudder_missing", 16'(want.rudder_missing), 16'(got.rudder_missing));
            compare_field("eeprom_pair_done", 16'(want.eeprom_pair_done),
                          16'(got.eeprom_pair_done));
            compare_field("eeprom_pair_addr", 16'(want.eeprom_pair_addr),
                          16'(got.eeprom_pair_addr));
            compare_field("eeprom_pair_word", want.eeprom_pair_word, got.eeprom_pair_word);
            compare_field("version_number", 16'(want.version_number), 16'(got.version_number));
            compare_field("packets_seen", 16'(want.packets_seen), 16'(got.packets_seen));
            compare_field("status_flags", want.status_flags, got.status_flags);
        endfunction
    endclass

    packet_decode_scoreboard sb;
    int     bytes_sent;
    int     idle_cycles;
    // While set, neither side inserts gaps, giving back-to-back stretches.
    bit     no_idle;
    t_result seen_packet;

    assign seen_packet = {o_kind, o_raw_value, o_rudder_missing, o_eeprom_pair_done,
                          o_eeprom_pair_addr, o_eeprom_pair_word, o_version_number,
                          o_packets_seen, o_status_flags};

    // The clock starts low; the first rising edge comes half a period in.
    always begin
        i_clk = 1'b0;
        #HALF_PERIOD;
        i_clk = 1'b1;
        #HALF_PERIOD;
    end

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 50) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side pacing. Each pass starts at a falling edge and makes one
    // assignment per edge: a stall of random length, then a run of ready.
    initial begin : result_pacing
        int stall;
        i_ready = 1'b0;
        @(negedge i_clk);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    end

    // Every delivered packet is checked at the rising edge that takes it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_packet(seen_packet);
        end
    end

    // Hang detection: count edges at which neither channel moves an item.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("crc8_telemetry_packet_deframer_unit_tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one byte after a random gap and returns at the edge that takes it.
    // Valid is only touched at falling edges after the previous acceptance, so
    // it is either dropped for the gap or handed the next byte, never both.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    // Sends a four-byte frame. With bad_pos in 0..3 that byte is flipped by
    // bad_mask, which breaks the CRC or the sync on the receive side.
    task automatic send_frame(input logic [7:0] code, input logic [15:0] val,
                              input int bad_pos, input logic [7:0] bad_mask);
        logic [7:0] fr [4];
        fr = '{code, val[7:0], val[15:8], frame_crc(code, val[7:0], val[15:8])};
        if (bad_pos >= 0) fr[bad_pos] = fr[bad_pos] ^ bad_mask;
        for (int k = 0; k < 4; k++) send_byte(fr[k]);
    endtask

    // Holds the sender off until the block has delivered everything owed.
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending_packets.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_known_code();
        case ($urandom_range(0, 7))
            0:       return CODE_CURRENT;
            1:       return CODE_VOLTAGE;
            2:       return CODE_CTRL_TEMP;
            3:       return CODE_MOTOR_TEMP;
            4:       return CODE_RUDDER;
            5:       return CODE_FLAGS;
            6:       return CODE_EEPROM;
            default: return CODE_VERSION;
        endcase
    endfunction

    initial begin : stimulus
        logic [7:0]  code;
        logic [15:0] val;
        int          roll;
        int          next_toggle;
        bit          paused;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_rx_byte = 8'h00;
        no_idle = 1'b0;
        bytes_sent = 0;
        paused = 1'b0;
        next_toggle = 150;
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames. The first two good frames only build sync; after
        // that come a rudder packet with no rudder data, an EEPROM pair at
        // an even then an odd address, and the largest version number.
        send_frame(CODE_CURRENT, 16'h0000, -1, 8'h00);
        send_frame(CODE_VOLTAGE, 16'hFFFF, -1, 8'h00);
        send_frame(CODE_RUDDER, RUDDER_NONE, -1, 8'h00);
        send_frame(CODE_EEPROM, 16'hAB10, -1, 8'h00);
        send_frame(CODE_EEPROM, 16'hCD11, -1, 8'h00);
        send_frame(CODE_VERSION, 16'hFFFF, -1, 8'h00);

        // Random part: mostly well-formed frames with random content, the
        // rest loose noise bytes and frames with one damaged byte, both of
        // which knock the block out of sync and make it hunt for alignment.
        while (bytes_sent < RANDOM_BYTES) begin
            if (bytes_sent >= next_toggle) begin
                no_idle = ($urandom_range(0, 3) == 0);
                next_toggle += 150;
            end
            if (!paused && bytes_sent >= RANDOM_BYTES / 2) begin
                drain_results();
                paused = 1'b1;
            end
            code = ($urandom_range(0, 99) < 85) ? pick_known_code() : 8'($urandom);
            roll = $urandom_range(0, 99);
            if (roll < 8) val = 16'hFFFF;
            else if (roll < 16) val = 16'h0000;
            else val = 16'($urandom);
            if (code == CODE_EEPROM) begin
                roll = $urandom_range(0, 99);
                // Aim at the stored partner often enough to complete pairs.
                if (roll < 40) val[7:0] = sb.even_addr + 8'd1;
                else if (roll < 70) val[0] = 1'b0;
            end
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            end else if (roll < 9) begin
                send_frame(code, val, $urandom_range(0, 3), 8'($urandom_range(1, 255)));
            end else begin
                send_frame(code, val, -1, 8'h00);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d bytes, %0d decoded packets, %0d CRC slips, %0d EEPROM pairs",
                 bytes_sent, sb.decoded_total, sb.crc_drops, sb.pairs_done);
        $display("final packet count %0d, %0d mismatches", sb.pkt_cnt, sb.errors);
        if (sb.errors == 0) begin
            $display("crc8_telemetry_packet_deframer_unit_tb: done, clean");
        end else begin
            $display("crc8_telemetry_packet_deframer_unit_tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
src/ctpd_pkg.sv
src/ctpd_decode.sv
src/crc8_telemetry_packet_deframer_unit.sv
tb/crc8_telemetry_packet_deframer_unit_tb.sv
